@@ rtl/rxb_pkg.sv @@
// ----------------------------------------------------------------------------
// rxb_pkg
// shared constants, codes, types and ring address helper for the receive
// byte buffer with delimited reads
// ----------------------------------------------------------------------------
package rxb_pkg;

	// ring size and derived widths
	localparam int BUFFER_DEPTH = 64;
	localparam int AW           = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);

	// action codes
	localparam logic [2:0] ACT_APPEND   = 3'd0;
	localparam logic [2:0] ACT_READ_CNT = 3'd1;
	localparam logic [2:0] ACT_READ_TRM = 3'd2;
	localparam logic [2:0] ACT_READ_ALL = 3'd3;
	localparam logic [2:0] ACT_FLUSH    = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} fsm_state_t;

	// memory access from the sequencer
	typedef struct packed {
		logic          we;
		logic [AW-1:0] waddr;
		logic [7:0]    wdata;
		logic [AW-1:0] raddr;
	} mem_req_t;

	// result fields that travel alongside the memory read
	typedef struct packed {
		logic       valid;
		logic       byte_valid;
		logic       last;
		logic [6:0] count;
		logic       found;
		logic       now_empty;
		logic       overflowed;
	} res_t;

	// base + offset modulo the ring size, base below depth, offset at most depth
	function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
		input logic [CNT_W-1:0] off);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
		if (sum >= (CNT_W+1)'(BUFFER_DEPTH)) begin
			sum = sum - (CNT_W+1)'(BUFFER_DEPTH);
		end
		return sum[AW-1:0];
	endfunction

endpackage

@@ rtl/rxb_ram.sv @@
// ----------------------------------------------------------------------------
// rxb_ram
// byte ring storage, one write and one registered read port
// ----------------------------------------------------------------------------
module rxb_ram
	import rxb_pkg::*;
(
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [BUFFER_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/rxb_ctrl.sv @@
// ----------------------------------------------------------------------------
// rxb_ctrl
// ring pointers, overflow flag and read sequencer (scan and emit passes)
// ----------------------------------------------------------------------------
module rxb_ctrl
	import rxb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [2:0] action,
	input  logic [7:0] data_byte,
	input  logic [6:0] read_count,
	input  logic [7:0] terminator,
	input  logic [7:0] rdata,
	output logic       busy,
	output mem_req_t   mem_req,
	output res_t       res_s1
);

	fsm_state_t       state_q, state_d;
	logic [AW-1:0]    rp_q;
	logic [CNT_W-1:0] uc_q;
	logic             ovf_q;
	logic [7:0]       term_q;
	logic [CNT_W-1:0] n_q;
	logic             found_q;
	logic [CNT_W-1:0] idx_q;
	logic             sv_s1;
	logic [CNT_W-1:0] sidx_s1;

	logic             accept;
	logic             is_read;
	logic [6:0]       uc_ext;
	logic [CNT_W-1:0] n_cnt;
	logic             scan_hit;
	logic             term_match;
	logic             emit_last;

	assign accept     = start && !busy;
	assign is_read    = (action == ACT_READ_CNT) || (action == ACT_READ_TRM)
		|| (action == ACT_READ_ALL);
	assign uc_ext     = 7'(uc_q);
	assign n_cnt      = (read_count < uc_ext) ? CNT_W'(read_count) : uc_q;
	assign term_match = (rdata == term_q);
	assign scan_hit   = (state_q == ST_SCAN) && sv_s1
		&& (term_match || (sidx_s1 + 1'b1 == uc_q));
	assign emit_last  = (state_q == ST_EMIT) && ((n_q == '0) || (idx_q + 1'b1 == n_q));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && is_read) begin
					if (action == ACT_READ_TRM && uc_q != '0) begin
						state_d = ST_SCAN;
					end else begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_SCAN: begin
				if (scan_hit) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (emit_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy          = (state_q != ST_IDLE);
		mem_req.we    = (state_q == ST_IDLE) && accept && (action == ACT_APPEND)
			&& (uc_q != CNT_W'(BUFFER_DEPTH));
		mem_req.waddr = ring_add(rp_q, uc_q);
		mem_req.wdata = data_byte;
		mem_req.raddr = ring_add(rp_q, idx_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rp_q    <= '0;
			uc_q    <= '0;
			ovf_q   <= 1'b0;
			term_q  <= '0;
			n_q     <= '0;
			found_q <= 1'b0;
			idx_q   <= '0;
			sv_s1   <= 1'b0;
			sidx_s1 <= '0;
		end else begin
			state_q <= state_d;
			sv_s1   <= (state_q == ST_SCAN);
			sidx_s1 <= idx_q;
			unique case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (accept) begin
						case (action)
							ACT_APPEND: begin
								if (uc_q == CNT_W'(BUFFER_DEPTH)) begin
									ovf_q <= 1'b1;
								end else begin
									uc_q <= uc_q + 1'b1;
								end
							end
							ACT_FLUSH: begin
								rp_q  <= '0;
								uc_q  <= '0;
								ovf_q <= 1'b0;
							end
							ACT_READ_CNT: begin
								n_q     <= n_cnt;
								found_q <= 1'b0;
							end
							ACT_READ_TRM: begin
								term_q  <= terminator;
								n_q     <= '0;
								found_q <= 1'b0;
							end
							ACT_READ_ALL: begin
								n_q     <= uc_q;
								found_q <= (uc_q != '0);
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					if (scan_hit) begin
						n_q     <= sidx_s1 + 1'b1;
						found_q <= term_match;
						idx_q   <= '0;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_EMIT: begin
					idx_q <= idx_q + 1'b1;
					if (emit_last) begin
						rp_q <= (uc_q == n_q) ? '0 : ring_add(rp_q, n_q);
						uc_q <= uc_q - n_q;
					end
				end
				default: ;
			endcase
		end
	end

	// result fields for the address issued this cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s1 <= '0;
		end else begin
			res_s1.valid      <= (state_q == ST_EMIT);
			res_s1.byte_valid <= (n_q != '0);
			res_s1.last       <= emit_last;
			res_s1.count      <= emit_last ? 7'(n_q) : 7'd0;
			res_s1.found      <= emit_last && found_q;
			res_s1.now_empty  <= (uc_q == n_q);
			res_s1.overflowed <= ovf_q;
		end
	end

endmodule

@@ rtl/serial_rx_buffer_delimited_read.sv @@
// ----------------------------------------------------------------------------
// serial_rx_buffer_delimited_read
// receive byte ring with append, counted, terminated and full reads, flush
// ----------------------------------------------------------------------------
// append and flush emit nothing; busy stays low
// a counted read or read all keeps busy high through its emit pass
// a terminated read first scans up to the terminator, or over all unread
// bytes if none is found, no scan on an empty ring, then emits like a counted read
// results pass the result register and the output register, one per cycle
// the receiver cannot stall: each result shows for one cycle on strobe
// reset clears pointers, count and overflow at once; byte storage is not cleared
module serial_rx_buffer_delimited_read
	import rxb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [2:0] action,
	input  logic [7:0] data_byte,
	input  logic [6:0] read_count,
	input  logic [7:0] terminator,
	output logic       strobe,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       last,
	output logic [6:0] out_count,
	output logic       found,
	output logic       now_empty,
	output logic       overflowed
);

	mem_req_t   mem_req;
	res_t       res_s1;
	logic [7:0] rdata;

	// sequencer: pointers, overflow flag, scan and emit passes
	rxb_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.action     (action),
		.data_byte  (data_byte),
		.read_count (read_count),
		.terminator (terminator),
		.rdata      (rdata),
		.busy       (busy),
		.mem_req    (mem_req),
		.res_s1     (res_s1)
	);

	// ring storage, read data arrives in the cycle after the address
	rxb_ram u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.raddr (mem_req.raddr),
		.rdata (rdata)
	);

	// output register: read data joins its result fields here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= res_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		out_byte   <= res_s1.byte_valid ? rdata : 8'd0;
		byte_valid <= res_s1.byte_valid;
		last       <= res_s1.last;
		out_count  <= res_s1.count;
		found      <= res_s1.found;
		now_empty  <= res_s1.now_empty;
		overflowed <= res_s1.overflowed;
	end

	// storage is only written by an append taken while idle
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.we |-> !busy)
		else $error("ring write while a read is in progress");

	// an empty result closes its read with nothing to report
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !byte_valid) |-> (last && out_count == 7'd0 && !found))
		else $error("empty result with bad fields");

	// every read ends with a last result in the cycle after busy drops
	a_last_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |=> (strobe && last))
		else $error("read finished without a last result");

	// results before the last carry bytes and no count
	a_mid_result: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last) |-> (byte_valid && out_count == 7'd0 && !found))
		else $error("intermediate result with bad fields");

endmodule

@@ tb/sv/rx_buffer_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rx_buffer_checker
// watches the command and result ports of the receive byte buffer, keeps its
// own copy of the ring, predicts the results of every accepted transaction
// and compares each strobed result with the oldest prediction
// ----------------------------------------------------------------------------
module rx_buffer_checker
	import rxb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       busy,
	input  logic [2:0] action,
	input  logic [7:0] data_byte,
	input  logic [6:0] read_count,
	input  logic [7:0] terminator,
	input  logic       strobe,
	input  logic [7:0] out_byte,
	input  logic       byte_valid,
	input  logic       last,
	input  logic [6:0] out_count,
	input  logic       found,
	input  logic       now_empty,
	input  logic       overflowed,
	output int         errors,
	output int         outstanding,
	output int         results_checked,
	output int         dropped_appends
);

	typedef struct packed {
		logic [7:0] data;
		logic       byte_valid;
		logic       last;
		logic [6:0] count;
		logic       found;
		logic       now_empty;
		logic       overflowed;
	} rx_result_t;

	logic [7:0]  ring [BUFFER_DEPTH];
	int unsigned head;
	int unsigned unread;
	logic        ovf;
	rx_result_t  pending_results [$];

	// update the ring copy for one transaction and queue the bytes it returns
	task automatic predict_read(input logic [2:0] act, input logic [7:0] din,
		input logic [6:0] want, input logic [7:0] term);
		int unsigned n;
		int unsigned left;
		logic        hit;
		rx_result_t  r;
		n = 0;
		hit = 1'b0;
		case (act)
			ACT_APPEND: begin
				if (unread >= BUFFER_DEPTH) begin
					ovf = 1'b1;
					dropped_appends++;
				end else begin
					ring[(head + unread) % BUFFER_DEPTH] = din;
					unread++;
				end
				return;
			end
			ACT_FLUSH: begin
				head = 0;
				unread = 0;
				ovf = 1'b0;
				return;
			end
			ACT_READ_CNT: n = (want < unread) ? want : unread;
			ACT_READ_TRM: begin
				while (n < unread && !hit) begin
					hit = (ring[(head + n) % BUFFER_DEPTH] == term);
					n++;
				end
			end
			ACT_READ_ALL: begin
				n = unread;
				hit = (n > 0);
			end
			default: return;
		endcase
		left = unread - n;
		if (n == 0) begin
			r = '{data: 8'h00, byte_valid: 1'b0, last: 1'b1, count: 7'd0, found: 1'b0,
				now_empty: (left == 0), overflowed: ovf};
			pending_results.push_back(r);
		end
		for (int unsigned i = 0; i < n; i++) begin
			r.data       = ring[(head + i) % BUFFER_DEPTH];
			r.byte_valid = 1'b1;
			r.last       = (i + 1 == n);
			r.count      = r.last ? 7'(n) : 7'd0;
			r.found      = r.last ? hit : 1'b0;
			r.now_empty  = (left == 0);
			r.overflowed = ovf;
			pending_results.push_back(r);
		end
		head = (head + n) % BUFFER_DEPTH;
		unread = left;
		if (unread == 0)
			head = 0;
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		rx_result_t seen;
		rx_result_t want;
		if (!arst_n) begin
			head = 0;
			unread = 0;
			ovf = 1'b0;
			pending_results.delete();
			errors = 0;
			results_checked = 0;
			dropped_appends = 0;
		end else begin
			if (strobe) begin
				seen = {out_byte, byte_valid, last, out_count, found, now_empty, overflowed};
				results_checked++;
				if (pending_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, actual byte=%02h valid=%0d last=%0d count=%0d found=%0d empty=%0d ovf=%0d",
						$time, seen.data, seen.byte_valid, seen.last, seen.count,
						seen.found, seen.now_empty, seen.overflowed);
				end else begin
					want = pending_results.pop_front();
					if (seen !== want) begin
						errors++;
						$display("%0t: result mismatch, expected byte=%02h valid=%0d last=%0d count=%0d found=%0d empty=%0d ovf=%0d",
							$time, want.data, want.byte_valid, want.last, want.count,
							want.found, want.now_empty, want.overflowed);
						$display("%0t:                   actual byte=%02h valid=%0d last=%0d count=%0d found=%0d empty=%0d ovf=%0d",
							$time, seen.data, seen.byte_valid, seen.last, seen.count,
							seen.found, seen.now_empty, seen.overflowed);
					end
				end
			end
			if (start && !busy)
				predict_read(action, data_byte, read_count, terminator);
		end
		outstanding = pending_results.size();
	end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the receive byte buffer with delimited reads: a
// directed pass over empty, oversized, terminated and flushed reads, then
// random append bursts and reads under three sender idle profiles, with the
// checker predicting and comparing every strobed result
// ----------------------------------------------------------------------------
module testbench;
	import rxb_pkg::*;

	localparam int CLK_HALF        = 4;
	localparam int RESET_CYCLES    = 7;
	localparam int CYCLE_LIMIT     = 400000;
	localparam int TAIL_CYCLES     = 16;
	localparam int ITEMS_PER_PHASE = 60;

	// codes the block must ignore
	localparam logic [2:0] ACT_RSVD_5 = 3'd5;
	localparam logic [2:0] ACT_RSVD_6 = 3'd6;
	localparam logic [2:0] ACT_RSVD_7 = 3'd7;

	logic       clk;
	logic       arst_n     = 1'b0;
	logic       start      = 1'b0;
	logic [2:0] action     = ACT_APPEND;
	logic [7:0] data_byte  = 8'h00;
	logic [6:0] read_count = 7'd0;
	logic [7:0] terminator = 8'h00;
	logic       busy;
	logic       strobe;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       last;
	logic [6:0] out_count;
	logic       found;
	logic       now_empty;
	logic       overflowed;

	int errors;
	int outstanding;
	int results_checked;
	int dropped_appends;
	int idle_pct   = 0;
	int items_sent = 0;
	int cycles     = 0;

	serial_rx_buffer_delimited_read u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.action     (action),
		.data_byte  (data_byte),
		.read_count (read_count),
		.terminator (terminator),
		.strobe     (strobe),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.last       (last),
		.out_count  (out_count),
		.found      (found),
		.now_empty  (now_empty),
		.overflowed (overflowed)
	);

	rx_buffer_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.action          (action),
		.data_byte       (data_byte),
		.read_count      (read_count),
		.terminator      (terminator),
		.strobe          (strobe),
		.out_byte        (out_byte),
		.byte_valid      (byte_valid),
		.last            (last),
		.out_count       (out_count),
		.found           (found),
		.now_empty       (now_empty),
		.overflowed      (overflowed),
		.errors          (errors),
		.outstanding     (outstanding),
		.results_checked (results_checked),
		.dropped_appends (dropped_appends)
	);

	// free-running clock, 8 ns period
	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// watchdog on total run length
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still expected", cycles, outstanding);
			$display("tb: failure");
			$finish;
		end
	end

	// one command transaction: optional idle gap, then hold start until busy is low
	task automatic send_item(input logic [2:0] act, input logic [7:0] din,
		input logic [6:0] cnt, input logic [7:0] term);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start      <= 1'b1;
		action     <= act;
		data_byte  <= din;
		read_count <= cnt;
		terminator <= term;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (act <= ACT_FLUSH)
			items_sent++;
	endtask

	// bias bytes toward a few line delimiters so terminated reads hit often
	function automatic logic [7:0] pick_byte();
		if ($urandom_range(99) < 40) begin
			case ($urandom_range(3))
				0:       return 8'h0A;
				1:       return 8'h0D;
				2:       return 8'h00;
				default: return 8'hFF;
			endcase
		end
		return 8'($urandom_range(255));
	endfunction

	// unused fields of an append still toggle at random
	task automatic send_append();
		send_item(ACT_APPEND, pick_byte(), 7'($urandom_range(64)), 8'($urandom_range(255)));
	endtask

	task automatic send_read();
		int         pick;
		logic [2:0] act;
		logic [6:0] cnt;
		pick = $urandom_range(99);
		if (pick < 45)
			act = ACT_READ_CNT;
		else if (pick < 85)
			act = ACT_READ_TRM;
		else
			act = ACT_READ_ALL;
		// mostly short counts, sometimes the whole ring
		case ($urandom_range(9))
			0:       cnt = 7'd64;
			1:       cnt = 7'($urandom_range(64));
			default: cnt = 7'($urandom_range(12));
		endcase
		send_item(act, 8'($urandom_range(255)), cnt, pick_byte());
	endtask

	initial begin : stimulus
		int kind;
		int target;
		bit first_burst;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every read kind on an empty ring gives one empty result
		send_item(ACT_READ_CNT, 8'h00, 7'd63, 8'h00);
		send_item(ACT_READ_TRM, 8'h00, 7'd0, 8'h0A);
		send_item(ACT_READ_ALL, 8'h00, 7'd0, 8'h00);
		// byte extremes, then a zero count read
		send_item(ACT_APPEND, 8'h00, 7'd0, 8'h00);
		send_item(ACT_APPEND, 8'hFF, 7'd127, 8'hFF);
		send_item(ACT_APPEND, 8'h0A, 7'd0, 8'h00);
		send_item(ACT_APPEND, 8'h55, 7'd0, 8'h00);
		send_item(ACT_READ_CNT, 8'h00, 7'd0, 8'h00);
		// terminator present, then terminator missing drains the ring
		send_item(ACT_READ_TRM, 8'h00, 7'd0, 8'h0A);
		send_item(ACT_READ_TRM, 8'h00, 7'd0, 8'h77);
		// unused codes in between must leave the ring alone
		send_item(ACT_APPEND, 8'h41, 7'd0, 8'h00);
		send_item(ACT_APPEND, 8'h42, 7'd0, 8'h00);
		send_item(ACT_RSVD_5, 8'hFF, 7'd64, 8'hFF);
		send_item(ACT_RSVD_6, 8'hAA, 7'd21, 8'h55);
		send_item(ACT_RSVD_7, 8'h55, 7'd42, 8'hAA);
		// count above what is unread
		send_item(ACT_READ_CNT, 8'h00, 7'd64, 8'h00);
		// flush discards unread bytes
		send_item(ACT_APPEND, 8'h11, 7'd0, 8'h00);
		send_item(ACT_FLUSH, 8'h00, 7'd0, 8'h00);
		send_item(ACT_READ_ALL, 8'h00, 7'd0, 8'h00);
		send_item(ACT_APPEND, 8'h80, 7'd0, 8'h00);
		send_item(ACT_APPEND, 8'h7F, 7'd0, 8'h00);
		send_item(ACT_READ_ALL, 8'h00, 7'd0, 8'h00);

		// random: busy sender, then a sparse one, then back to back
		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 12 : (phase == 1) ? 76 : 0;
			target = items_sent + ITEMS_PER_PHASE;
			first_burst = (phase == 0);
			while (items_sent < target) begin
				kind = first_burst ? 0 : $urandom_range(99);
				first_burst = 1'b0;
				if (kind < 12) begin
					// fill near or past capacity so appends can get dropped
					repeat ($urandom_range(60, 70)) send_append();
				end else if (kind < 72) begin
					repeat ($urandom_range(1, 12)) send_append();
					repeat ($urandom_range(1, 3)) send_read();
				end else if (kind < 92) begin
					repeat ($urandom_range(1, 3)) send_read();
				end else if (kind < 96) begin
					send_item(ACT_FLUSH, 8'($urandom_range(255)), 7'($urandom_range(64)),
						8'($urandom_range(255)));
				end else begin
					// noise with an ignored code
					send_item(3'($urandom_range(ACT_RSVD_5, ACT_RSVD_7)),
						8'($urandom_range(255)), 7'($urandom_range(64)),
						8'($urandom_range(255)));
				end
			end
		end
		start <= 1'b0;

		// drain every expected result, then watch for strays
		repeat (2) @(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d transactions over three sender idle profiles, %0d results checked",
			items_sent, results_checked);
		$display("%0d appends dropped on a full ring, %0d mismatches", dropped_appends, errors);
		if (errors == 0 && outstanding == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
